>>> src/dlts_pkg.sv
// ============================================================================
// dlts_pkg
// Shared types and codes for the delta-list task scheduler.
// ============================================================================
package dlts_pkg;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_DELETE   = 2'd2,
        KIND_DISPATCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    // one list entry
    typedef struct packed {
        logic [7:0]  handle;
        logic [31:0] delay;
        logic [31:0] period;
        logic        ready;
        logic [15:0] id;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_UP,   // take the lower neighbor's entry (cells above pos)
        OP_SHIFT_DOWN, // take the upper neighbor's entry (cells at/after k)
        OP_WRITE,      // load the new entry (cell pos)
        OP_SUB,        // delay -= operand (successor trim)
        OP_ADD,        // delay += operand (successor merge)
        OP_DEC,        // delay -= 1
        OP_MARK        // set ready
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] operand;
        entry_t      wr;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_WALK,
        S_SHIFT_UP,
        S_WRITE,
        S_TRIM,
        S_REMOVE,
        S_SHIFT_DOWN
    } state_t;

endpackage

>>> src/dlts_cell.sv
// ============================================================================
// dlts_cell
// One slot of the list: holds an entry, shifts with its neighbors.
// ============================================================================
module dlts_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sel,
    input  logic               shift_en,
    input  dlts_pkg::cell_cmd_t cmd,
    input  dlts_pkg::entry_t   lower,
    input  dlts_pkg::entry_t   upper,
    output dlts_pkg::entry_t   q
);
    import dlts_pkg::*;

    entry_t ent_reg, ent_next;

    // next entry
    always_comb
    begin
        ent_next = ent_reg;
        unique case (cmd.op)
            OP_SHIFT_UP:   if (shift_en) ent_next = lower;
            OP_SHIFT_DOWN: if (shift_en) ent_next = upper;
            OP_WRITE:      if (sel) ent_next = cmd.wr;
            OP_SUB:        if (sel) ent_next.delay = ent_reg.delay - cmd.operand;
            OP_ADD:        if (sel) ent_next.delay = ent_reg.delay + cmd.operand;
            OP_DEC:        if (sel) ent_next.delay = ent_reg.delay - 32'd1;
            OP_MARK:       if (sel) ent_next.ready = 1'b1;
            default:       ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end

    assign q = ent_reg;
endmodule

>>> src/delta_list_task_scheduler_core.sv
// ============================================================================
// delta_list_task_scheduler_core
// Delta-sorted timer task list built as a row of shifting cells.
// ============================================================================
// Usage: drive kind/task_handle/delay/period/task_id and raise start while
// busy is low; the word is taken at that edge. Exactly one result word
// (status, result_id, run_valid, run_handle) appears with done high for one
// cycle. The receiver cannot stall; results are never held.
// The sequencer visits one cell per cycle. A countdown tick, a tick or
// dispatch with nothing to do, and a reject of a bad handle, a full list
// or a zero delete id are answered straight from idle. A marking tick
// marks each leading zero-delay entry in turn. An add walks up to
// MAX_TASKS-1 cells, then shifts up, writes, and trims the successor when
// there is one. A delete searches up to MAX_TASKS cells, then merges into
// the successor and shifts down. A one-shot dispatch removes the head and
// shifts down; a periodic one then runs the add. The next word can be
// taken in the cycle of the result.
// Reset clears all cells, the id counter and the sequencer; the block can
// accept a word in the first cycle after reset.
// ============================================================================
module delta_list_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  task_handle,
    input  logic [31:0] delay,
    input  logic [31:0] period,
    input  logic [15:0] task_id,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] result_id,
    output logic        run_valid,
    output logic [7:0]  run_handle
);
    import dlts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    // cell row
    entry_t    ent [MAX_TASKS];
    cell_cmd_t cmd;
    logic [MAX_TASKS-1:0] sel_vec, shf_vec;

    // sequencer registers
    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  hd_reg, hd_next;
    logic [31:0] dly_reg, dly_next;
    logic [31:0] per_reg, per_next;
    logic [15:0] tid_reg, tid_next;
    logic [CW-1:0] ptr_reg, ptr_next;   // walk position
    logic [CW-1:0] cnt_reg, cnt_next;   // occupied count
    logic [15:0] nid_reg, nid_next;
    logic        insert_reg, insert_next; // walking for insert (vs delete)
    logic [1:0]  st_reg, st_next;
    logic [15:0] rid_reg, rid_next;
    logic        rv_reg, rv_next;
    logic [7:0]  rh_reg, rh_next;
    logic        done_reg, done_next;

    logic [IW-1:0] pidx;
    entry_t cur;
    logic   cur_occ;
    logic [15:0] fresh;
    logic [15:0] use_id;
    logic [CW-1:0] ptr_inc;

    assign pidx    = ptr_reg[IW-1:0];
    assign ptr_inc = ptr_reg + CW'(1);
    assign cur     = ent[pidx];
    assign cur_occ = (ptr_reg < cnt_reg);
    assign fresh   = (nid_reg == 16'hFFFF) ? 16'd1 : nid_reg + 16'd1;
    assign use_id  = (tid_reg != '0) ? tid_reg : fresh;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            entry_t lo, up;
            if (g == 0)
            begin : g_lo0
                assign lo = '0;
            end
            else
            begin : g_lo
                assign lo = ent[g-1];
            end
            if (g == MAX_TASKS - 1)
            begin : g_upn
                assign up = '0;
            end
            else
            begin : g_up
                assign up = ent[g+1];
            end
            dlts_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .sel      (sel_vec[g]),
                .shift_en (shf_vec[g]),
                .cmd      (cmd),
                .lower    (lo),
                .upper    (up),
                .q        (ent[g])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        hd_next     = hd_reg;
        dly_next    = dly_reg;
        per_next    = per_reg;
        tid_next    = tid_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        nid_next    = nid_reg;
        insert_next = insert_reg;
        st_next     = st_reg;
        rid_next    = rid_reg;
        rv_next     = rv_reg;
        rh_next     = rh_reg;
        done_next   = 1'b0;
        cmd         = '0;
        cmd.op      = OP_HOLD;
        sel_vec     = '0;
        shf_vec     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind_t'(kind);
                    hd_next   = task_handle;
                    dly_next  = delay;
                    per_next  = period;
                    tid_next  = task_id;
                    ptr_next  = '0;
                    st_next   = ST_OK;
                    rid_next  = '0;
                    rv_next   = 1'b0;
                    rh_next   = '0;
                    unique case (kind_t'(kind))
                        KIND_TICK:
                        begin
                            if (cnt_reg != '0 && !ent[0].ready)
                            begin
                                if (ent[0].delay != '0)
                                begin
                                    cmd.op = OP_DEC;
                                    sel_vec[0] = 1'b1;
                                    done_next = 1'b1;
                                end
                                else
                                    state_next = S_MARK;
                            end
                            else
                                done_next = 1'b1;
                        end
                        KIND_ADD:
                        begin
                            insert_next = 1'b1;
                            tid_next    = '0;
                            if (task_handle == '0)
                            begin
                                st_next = ST_BAD_HANDLE;
                                done_next = 1'b1;
                            end
                            else if (cnt_reg == CW'(MAX_TASKS))
                            begin
                                st_next = ST_FULL;
                                done_next = 1'b1;
                            end
                            else
                                state_next = S_WALK;
                        end
                        KIND_DELETE:
                        begin
                            insert_next = 1'b0;
                            if (task_id == '0)
                            begin
                                st_next = ST_NOT_FOUND;
                                done_next = 1'b1;
                            end
                            else
                                state_next = S_WALK;
                        end
                        KIND_DISPATCH:
                        begin
                            if (cnt_reg != '0 && ent[0].ready)
                            begin
                                rv_next  = 1'b1;
                                rh_next  = ent[0].handle;
                                rid_next = ent[0].id;
                                hd_next  = ent[0].handle;
                                dly_next = ent[0].period;
                                per_next = ent[0].period;
                                tid_next = ent[0].id;
                                state_next = S_REMOVE;
                            end
                            else
                                done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_MARK:
            begin
                // mark one leading zero-delay entry per cycle
                if (cur_occ && cur.delay == '0)
                begin
                    cmd.op = OP_MARK;
                    sel_vec[pidx] = 1'b1;
                    ptr_next = ptr_inc;
                    if (ptr_inc == cnt_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (insert_reg)
                begin
                    if (cur_occ && dly_reg >= cur.delay)
                    begin
                        dly_next = dly_reg - cur.delay;
                        ptr_next = ptr_inc;
                    end
                    else
                        state_next = S_SHIFT_UP;
                end
                else
                begin
                    if (!cur_occ)
                    begin
                        st_next    = ST_NOT_FOUND;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (cur.id == tid_reg)
                        state_next = S_REMOVE;
                    else
                        ptr_next = ptr_inc;
                end
            end
            S_SHIFT_UP:
            begin
                // open a gap at pos
                cmd.op = OP_SHIFT_UP;
                for (int i = 0; i < MAX_TASKS; i++)
                    shf_vec[i] = (CW'(i) > ptr_reg) && (CW'(i) <= cnt_reg);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // load the new entry, take a fresh id when none is carried
                cmd.op        = OP_WRITE;
                cmd.wr.handle = hd_reg;
                cmd.wr.delay  = dly_reg;
                cmd.wr.period = per_reg;
                cmd.wr.ready  = (dly_reg == '0);
                cmd.wr.id     = use_id;
                sel_vec[pidx] = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                rid_next      = use_id;
                if (tid_reg == '0)
                    nid_next = fresh;
                if (ptr_reg < cnt_reg)
                    state_next = S_TRIM;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TRIM:
            begin
                // successor keeps only the remainder
                cmd.op      = OP_SUB;
                cmd.operand = dly_reg;
                sel_vec[IW'(ptr_inc)] = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_REMOVE:
            begin
                // fold delay into successor
                if (ptr_inc < cnt_reg)
                begin
                    cmd.op = OP_ADD;
                    cmd.operand = cur.delay;
                    sel_vec[IW'(ptr_inc)] = 1'b1;
                end
                state_next = S_SHIFT_DOWN;
            end
            S_SHIFT_DOWN:
            begin
                // close the gap; a periodic dispatch re-inserts its task
                cmd.op = OP_SHIFT_DOWN;
                for (int i = 0; i < MAX_TASKS; i++)
                    shf_vec[i] = (CW'(i) >= ptr_reg);
                cnt_next = cnt_reg - CW'(1);
                if (kind_reg == KIND_DISPATCH && per_reg != '0)
                begin
                    insert_next = 1'b1;
                    ptr_next    = '0;
                    state_next  = S_WALK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= KIND_TICK;
            hd_reg     <= '0;
            dly_reg    <= '0;
            per_reg    <= '0;
            tid_reg    <= '0;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            nid_reg    <= '0;
            insert_reg <= 1'b0;
            st_reg     <= '0;
            rid_reg    <= '0;
            rv_reg     <= 1'b0;
            rh_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            hd_reg     <= hd_next;
            dly_reg    <= dly_next;
            per_reg    <= per_next;
            tid_reg    <= tid_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            nid_reg    <= nid_next;
            insert_reg <= insert_next;
            st_reg     <= st_next;
            rid_reg    <= rid_next;
            rv_reg     <= rv_next;
            rh_reg     <= rh_next;
            done_reg   <= done_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = st_reg;
    assign result_id  = rid_reg;
    assign run_valid  = rv_reg;
    assign run_handle = rh_reg;

    // assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_TASKS))
        else $error("occupancy out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");
    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && run_valid) |-> (status == ST_OK))
        else $error("dispatch with bad status");
endmodule

>>> dv/delta_list_task_scheduler_core_test.sv
// ============================================================================
// delta_list_task_scheduler_core_test
// Self-checking testbench for the delta-list task scheduler core. A directed
// table covers empty-list commands, bad handles, absent ids, delay extremes
// and the full-list reject. Random command traffic follows, with idle gaps
// on the command side. Every result word is compared with its directed table
// entry or, where the row gives none, with a local scheduler model.
// ============================================================================
module delta_list_task_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dlts_pkg::*;

    localparam int NTASK      = 16;
    localparam int N_RANDOM   = 900;
    localparam int DRAIN_WAIT = 60;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        status_t     status;
        logic [15:0] rid;
        logic        rv;
        logic [7:0]  rh;
    } sched_result_t;

    typedef struct {
        kind_t         k;
        logic [7:0]    h;
        logic [31:0]   d;
        logic [31:0]   p;
        logic [15:0]   id;
        bit            typed;
        sched_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [7:0]  task_handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [15:0] task_id;
    logic        done;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic        run_valid;
    logic [7:0]  run_handle;

    // scheduler model state
    entry_t      task_list[NTASK];
    logic [15:0] id_counter;

    sched_result_t pending_results[$];
    stim_row_t     stim_table[$];

    int errors;
    int cycles;
    int n_words;
    int n_results;
    int n_runs;
    int n_full;

    delta_list_task_scheduler_core #(.MAX_TASKS(NTASK)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .task_handle (task_handle),
        .delay       (delay),
        .period      (period),
        .task_id     (task_id),
        .done        (done),
        .status      (status),
        .result_id   (result_id),
        .run_valid   (run_valid),
        .run_handle  (run_handle)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ---------------------------------------------------------------- model
    function automatic void list_clear();
        for (int i = 0; i < NTASK; i++)
            task_list[i] = '0;
        id_counter = '0;
    endfunction

    // insert sorted; zero id draws a fresh one; returns 0 when full
    function automatic bit list_insert(logic [7:0] h, logic [31:0] d, logic [31:0] p,
                                       logic [15:0] id, output logic [15:0] got);
        int pos;
        int last;
        pos = 0;
        got = '0;
        while (pos < NTASK && task_list[pos].handle != 0 && d >= task_list[pos].delay) begin
            d = d - task_list[pos].delay;
            pos++;
        end
        last = pos;
        while (last < NTASK && task_list[last].handle != 0)
            last++;
        if (last >= NTASK)
            return 0;
        for (int i = last; i > pos; i--)
            task_list[i] = task_list[i-1];
        if (id == 0) begin
            id_counter = id_counter + 16'd1;
            if (id_counter == 0)
                id_counter = 16'd1;
            id = id_counter;
        end
        task_list[pos].handle = h;
        task_list[pos].delay  = d;
        task_list[pos].period = p;
        task_list[pos].ready  = (d == 0);
        task_list[pos].id     = id;
        if (pos < last)
            task_list[pos+1].delay = task_list[pos+1].delay - d;
        got = id;
        return 1;
    endfunction

    // remove slot k, folding its delay into the successor
    function automatic void list_remove(int k);
        int j;
        j = k;
        if (k + 1 < NTASK && task_list[k+1].handle != 0)
            task_list[k+1].delay = task_list[k+1].delay + task_list[k].delay;
        while (j + 1 < NTASK && task_list[j+1].handle != 0) begin
            task_list[j] = task_list[j+1];
            j++;
        end
        task_list[j] = '0;
    endfunction

    function automatic sched_result_t sched_predict(kind_t k, logic [7:0] h, logic [31:0] d,
                                                    logic [31:0] p, logic [15:0] tid);
        sched_result_t r;
        logic [15:0]   got;
        int            hit;
        entry_t        head;
        r = '{status: ST_OK, rid: '0, rv: 1'b0, rh: '0};
        case (k)
            KIND_TICK: begin
                if (task_list[0].handle != 0 && !task_list[0].ready) begin
                    if (task_list[0].delay != 0)
                        task_list[0].delay = task_list[0].delay - 32'd1;
                    else
                        for (int i = 0; i < NTASK; i++) begin
                            if (task_list[i].handle == 0 || task_list[i].delay != 0)
                                break;
                            task_list[i].ready = 1'b1;
                        end
                end
            end
            KIND_ADD: begin
                if (h == 0)
                    r.status = ST_BAD_HANDLE;
                else if (!list_insert(h, d, p, 16'd0, got))
                    r.status = ST_FULL;
                else
                    r.rid = got;
            end
            KIND_DELETE: begin
                hit = -1;
                if (tid != 0)
                    for (int i = 0; i < NTASK; i++)
                        if (task_list[i].id == tid) begin
                            hit = i;
                            break;
                        end
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    list_remove(hit);
            end
            default: begin
                head = task_list[0];
                if (head.handle != 0 && head.ready) begin
                    r.rv  = 1'b1;
                    r.rh  = head.handle;
                    r.rid = head.id;
                    list_remove(0);
                    if (head.period != 0)
                        void'(list_insert(head.handle, head.period, head.period, head.id, got));
                end
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, field, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        sched_result_t want;
        if (rst_n && done) begin
            n_results++;
            if (run_valid)
                n_runs++;
            if (status == ST_FULL)
                n_full++;
            if (pending_results.size() == 0) begin
                $display("unexpected result word at cycle %0d", cycles);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (status != want.status)
                    report_mismatch("status", status, want.status);
                if (result_id != want.rid)
                    report_mismatch("result_id", result_id, want.rid);
                if (run_valid != want.rv)
                    report_mismatch("run_valid", run_valid, want.rv);
                if (run_handle != want.rh)
                    report_mismatch("run_handle", run_handle, want.rh);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(99));
        if (r < 65)
            return 0;
        if (r < 95)
            return int'($urandom_range(3, 1));
        return int'($urandom_range(40, 10));
    endfunction

    function automatic void add_row(kind_t k, logic [7:0] h, logic [31:0] d, logic [31:0] p,
                                    logic [15:0] id, bit typed, status_t st,
                                    logic [15:0] rid, logic rv, logic [7:0] rh);
        stim_row_t row;
        row.k = k; row.h = h; row.d = d; row.p = p; row.id = id;
        row.typed = typed;
        row.res = '{status: st, rid: rid, rv: rv, rh: rh};
        stim_table.push_back(row);
    endfunction

    // drive one command word, wait for acceptance, record its expected result
    task automatic send_word(stim_row_t row, int gap);
        sched_result_t pred;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= row.k;
        task_handle <= row.h;
        delay       <= row.d;
        period      <= row.p;
        task_id     <= row.id;
        do
            @(posedge clk);
        while (busy);
        pred = sched_predict(row.k, row.h, row.d, row.p, row.id);
        if (row.typed)
            pending_results.push_back(row.res);
        else
            pending_results.push_back(pred);
        n_words++;
    endtask

    function automatic logic [31:0] rand_time();
        int r;
        r = int'($urandom_range(99));
        if (r < 70)
            return $urandom_range(6);
        if (r < 90)
            return $urandom_range(40);
        return $urandom();
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        int        r;
        int        live;
        row = '{k: KIND_TICK, h: '0, d: '0, p: '0, id: '0, typed: 1'b0,
                res: '{status: ST_OK, rid: '0, rv: 1'b0, rh: '0}};
        row.h  = 8'($urandom());
        row.d  = $urandom();
        row.p  = $urandom();
        row.id = 16'($urandom());
        r = int'($urandom_range(99));
        if (r < 35) begin
            row.k = KIND_TICK;
        end else if (r < 65) begin
            row.k = KIND_ADD;
            if ($urandom_range(19) == 0)
                row.h = '0;
            else if (row.h == 0)
                row.h = 8'd1;
            row.d = rand_time();
            row.p = ($urandom_range(2) == 0) ? 32'd0 : rand_time();
        end else if (r < 80) begin
            row.k = KIND_DELETE;
            live = 0;
            while (live < NTASK && task_list[live].handle != 0)
                live++;
            if (live > 0 && $urandom_range(9) < 7)
                row.id = task_list[$urandom_range(live - 1)].id;
            else if ($urandom_range(3) == 0)
                row.id = '0;
        end else begin
            row.k = KIND_DISPATCH;
        end
        return row;
    endfunction

    initial begin
        stim_row_t row;
        errors = 0; cycles = 0; n_words = 0; n_results = 0; n_runs = 0; n_full = 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= KIND_TICK;
        task_handle <= '0;
        delay       <= '0;
        period      <= '0;
        task_id     <= '0;
        list_clear();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, rejects, extremes, periodic rerun, full list
        add_row(KIND_TICK,     8'd0,   32'd0, 32'd0, 16'd0,      1, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_DISPATCH, 8'd0,   32'd0, 32'd0, 16'd0,      1, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_ADD,      8'd0,   32'd5, 32'd1, 16'd0,      1, ST_BAD_HANDLE, 16'd0, 0, 8'd0);
        add_row(KIND_DELETE,   8'd0,   32'd0, 32'd0, 16'd0,      1, ST_NOT_FOUND,  16'd0, 0, 8'd0);
        add_row(KIND_ADD,      8'd1,   32'd0, 32'd0, 16'd0,      1, ST_OK,         16'd1, 0, 8'd0);
        add_row(KIND_DISPATCH, 8'd0,   32'd0, 32'd0, 16'd0,      1, ST_OK,         16'd1, 1, 8'd1);
        add_row(KIND_ADD,      8'hFF,  '1,    '1,    16'hFFFF,   1, ST_OK,         16'd2, 0, 8'd0);
        add_row(KIND_ADD,      8'd2,   32'd1, 32'd3, 16'd0,      1, ST_OK,         16'd3, 0, 8'd0);
        add_row(KIND_TICK,     8'd0,   32'd0, 32'd0, 16'd0,      0, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_DISPATCH, 8'd0,   32'd0, 32'd0, 16'd0,      0, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_TICK,     8'd0,   32'd0, 32'd0, 16'd0,      0, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_DISPATCH, 8'd0,   32'd0, 32'd0, 16'd0,      0, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_DELETE,   8'd0,   32'd0, 32'd0, 16'd2,      1, ST_OK,         16'd0, 0, 8'd0);
        add_row(KIND_DELETE,   8'd0,   32'd0, 32'd0, 16'hFFFF,   1, ST_NOT_FOUND,  16'd0, 0, 8'd0);
        // fill the list; the last add must be rejected without using an id
        for (int i = 0; i < NTASK - 1; i++)
            add_row(KIND_ADD, 8'(i + 3), 32'(i), 32'd0, 16'd0, 0, ST_OK, 16'd0, 0, 8'd0);
        add_row(KIND_ADD,      8'd9,   32'd2, 32'd2, 16'd0,      1, ST_FULL,       16'd0, 0, 8'd0);

        foreach (stim_table[i])
            send_word(stim_table[i], pick_gap());

        // random traffic, with a stretch of back-to-back words in the middle
        for (int i = 0; i < N_RANDOM; i++) begin
            row = random_row();
            send_word(row, (i > 300 && i < 400) ? 0 : pick_gap());
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d command words sent, %0d results checked, %0d tasks run, %0d full rejects",
                 n_words, n_results, n_runs, n_full);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
